// File: hdl/per_core_register_divider_macros.svh
// assertion macros for the per-core register divider
`ifndef PER_CORE_REGISTER_DIVIDER_MACROS_SVH
`define PER_CORE_REGISTER_DIVIDER_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define PCRD_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pcrd check failed");

// consequent must hold in the cycle after the antecedent
`define PCRD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pcrd check failed");

`endif

// File: hdl/pcrd_pkg.sv
// shared types and constants for the per-core register divider
`default_nettype none

package pcrd_pkg;

  localparam int NUM_CORES = 2;
  localparam int CORE_W    = 1;
  localparam int DATA_W    = 32;
  localparam int STEP_W    = $clog2(DATA_W);

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef enum logic [2:0] {
    SEL_UDIVIDEND = 3'd0,
    SEL_UDIVISOR  = 3'd1,
    SEL_SDIVIDEND = 3'd2,
    SEL_SDIVISOR  = 3'd3,
    SEL_QUOTIENT  = 3'd4,
    SEL_REMAINDER = 3'd5,
    SEL_STATUS    = 3'd6,
    SEL_UNUSED    = 3'd7
  } reg_sel_t;

  // status register bit positions
  localparam int STAT_READY_BIT = 0;
  localparam int STAT_DIRTY_BIT = 1;

  typedef struct packed {
    logic start;
    logic is_signed;
  } div_req_t;

  typedef struct packed {
    logic done;
  } div_rsp_t;

endpackage

`default_nettype wire

// File: hdl/pcrd_divider.sv
// iterative restoring divider, one quotient bit per cycle, signed fixup at the end
`default_nettype none

module pcrd_divider (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire pcrd_pkg::div_req_t           req,
  input  wire logic [pcrd_pkg::DATA_W-1:0]  dividend,
  input  wire logic [pcrd_pkg::DATA_W-1:0]  divisor,
  output pcrd_pkg::div_rsp_t                rsp,
  output logic      [pcrd_pkg::DATA_W-1:0]  quotient,
  output logic      [pcrd_pkg::DATA_W-1:0]  remainder
);

  typedef enum logic [1:0] {
    D_IDLE,
    D_RUN,
    D_FIX
  } dstate_t;

  dstate_t                          state;
  logic [pcrd_pkg::STEP_W-1:0]      cnt;
  logic [pcrd_pkg::DATA_W-1:0]      rem;
  logic [pcrd_pkg::DATA_W-1:0]      quo;
  logic [pcrd_pkg::DATA_W-1:0]      dvs;
  logic                             neg_q;
  logic                             neg_r;

  logic                             n_neg;
  logic                             d_neg;
  logic [pcrd_pkg::DATA_W-1:0]      n_mag;
  logic [pcrd_pkg::DATA_W-1:0]      d_mag;
  logic [pcrd_pkg::DATA_W:0]        trial;
  logic [pcrd_pkg::DATA_W:0]        diff;

  always_comb begin
    n_neg = req.is_signed & dividend[pcrd_pkg::DATA_W-1];
    d_neg = req.is_signed & divisor[pcrd_pkg::DATA_W-1];
    n_mag = n_neg ? (~dividend + 1'b1) : dividend;
    d_mag = d_neg ? (~divisor + 1'b1) : divisor;
    // shared subtractor: shift in the next dividend bit and try the divisor
    trial = {rem, quo[pcrd_pkg::DATA_W-1]};
    diff  = trial - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= D_IDLE;
      cnt      <= '0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= (state == D_FIX);
      unique case (state)
        D_IDLE: begin
          if (req.start) begin
            rem   <= '0;
            quo   <= n_mag;
            dvs   <= d_mag;
            neg_q <= n_neg ^ d_neg;
            neg_r <= n_neg;
            cnt   <= '0;
            state <= D_RUN;
          end
        end
        D_RUN: begin
          if (diff[pcrd_pkg::DATA_W]) begin
            rem <= trial[pcrd_pkg::DATA_W-1:0];
            quo <= {quo[pcrd_pkg::DATA_W-2:0], 1'b0};
          end else begin
            rem <= diff[pcrd_pkg::DATA_W-1:0];
            quo <= {quo[pcrd_pkg::DATA_W-2:0], 1'b1};
          end
          cnt <= cnt + 1'b1;
          if (cnt == pcrd_pkg::STEP_W'(pcrd_pkg::DATA_W - 1)) begin
            state <= D_FIX;
          end
        end
        D_FIX: begin
          quotient  <= neg_q ? (~quo + 1'b1) : quo;
          remainder <= neg_r ? (~rem + 1'b1) : rem;
          state     <= D_IDLE;
        end
        default: begin
          state <= D_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hdl/per_core_register_divider.sv
// register-mapped per-core 32-bit divider: register file, access handling and divide control
// reads and writes return their result in the cycle after the transfer is accepted
// a dividend or divisor write with a nonzero divisor keeps in_stall high until write-back:
//   load in the accepting cycle, then 32 one-bit steps, one sign fixup, one write-back
// all other accesses can be accepted every cycle while the output is drained
// reset clears all operand, quotient and remainder registers, dirty and mode flags
`default_nettype none
`include "per_core_register_divider_macros.svh"

module per_core_register_divider (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         op,
  input  wire logic [pcrd_pkg::CORE_W-1:0]  core_id,
  input  wire logic [2:0]                   reg_sel,
  input  wire logic [pcrd_pkg::DATA_W-1:0]  write_data,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic      [pcrd_pkg::DATA_W-1:0]  read_data
);

  typedef enum logic {
    S_IDLE,
    S_BUSY
  } state_t;

  state_t                           state;
  logic [pcrd_pkg::CORE_W-1:0]      div_core;

  logic [pcrd_pkg::DATA_W-1:0]      dividend_reg  [pcrd_pkg::NUM_CORES];
  logic [pcrd_pkg::DATA_W-1:0]      divisor_reg   [pcrd_pkg::NUM_CORES];
  logic [pcrd_pkg::DATA_W-1:0]      quotient_reg  [pcrd_pkg::NUM_CORES];
  logic [pcrd_pkg::DATA_W-1:0]      remainder_reg [pcrd_pkg::NUM_CORES];
  logic [pcrd_pkg::NUM_CORES-1:0]   dirty_flag;
  logic [pcrd_pkg::NUM_CORES-1:0]   signed_mode;

  logic                             accept;
  logic                             core_ok;
  logic                             is_operand;
  pcrd_pkg::reg_sel_t               sel;
  logic [pcrd_pkg::DATA_W-1:0]      new_dividend;
  logic [pcrd_pkg::DATA_W-1:0]      new_divisor;
  logic [pcrd_pkg::DATA_W-1:0]      rd_value;
  pcrd_pkg::div_req_t               div_req;
  pcrd_pkg::div_rsp_t               div_rsp;
  logic [pcrd_pkg::DATA_W-1:0]      unit_quo;
  logic [pcrd_pkg::DATA_W-1:0]      unit_rem;

  assign in_stall = (state == S_BUSY) || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;
  assign sel      = pcrd_pkg::reg_sel_t'(reg_sel);
  assign core_ok  = 32'(core_id) < pcrd_pkg::NUM_CORES;

  always_comb begin
    is_operand   = (sel == pcrd_pkg::SEL_UDIVIDEND) || (sel == pcrd_pkg::SEL_UDIVISOR) ||
                   (sel == pcrd_pkg::SEL_SDIVIDEND) || (sel == pcrd_pkg::SEL_SDIVISOR);
    new_dividend = reg_sel[0] ? dividend_reg[core_id] : write_data;
    new_divisor  = reg_sel[0] ? write_data : divisor_reg[core_id];
    // signed registers sit at selector codes 2 and 3
    div_req.is_signed = reg_sel[1];
    div_req.start     = accept && core_ok && (op == pcrd_pkg::OP_WRITE) && is_operand &&
                        (new_divisor != '0);
  end

  always_comb begin
    rd_value = '0;
    unique case (sel)
      pcrd_pkg::SEL_UDIVIDEND, pcrd_pkg::SEL_SDIVIDEND: rd_value = dividend_reg[core_id];
      pcrd_pkg::SEL_UDIVISOR,  pcrd_pkg::SEL_SDIVISOR:  rd_value = divisor_reg[core_id];
      pcrd_pkg::SEL_QUOTIENT:  rd_value = quotient_reg[core_id];
      pcrd_pkg::SEL_REMAINDER: rd_value = remainder_reg[core_id];
      pcrd_pkg::SEL_STATUS: begin
        rd_value[pcrd_pkg::STAT_READY_BIT] = 1'b1;
        rd_value[pcrd_pkg::STAT_DIRTY_BIT] = dirty_flag[core_id];
      end
      pcrd_pkg::SEL_UNUSED: rd_value = '0;
      default: rd_value = '0;
    endcase
  end

  pcrd_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .req       (div_req),
    .dividend  (new_dividend),
    .divisor   (new_divisor),
    .rsp       (div_rsp),
    .quotient  (unit_quo),
    .remainder (unit_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      read_data   <= '0;
      div_core    <= '0;
      dirty_flag  <= '0;
      signed_mode <= '0;
      for (int i = 0; i < pcrd_pkg::NUM_CORES; i++) begin
        dividend_reg[i]  <= '0;
        divisor_reg[i]   <= '0;
        quotient_reg[i]  <= '0;
        remainder_reg[i] <= '0;
      end
    end else begin
      if (out_valid && !out_stall && !accept) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (div_req.start) begin
            div_core <= core_id;
            state    <= S_BUSY;
          end
        end
        S_BUSY: begin
          if (div_rsp.done) begin
            quotient_reg[div_core]  <= unit_quo;
            remainder_reg[div_core] <= unit_rem;
            state                   <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      if (accept) begin
        out_valid <= 1'b1;
        read_data <= (core_ok && (op == pcrd_pkg::OP_READ)) ? rd_value : '0;
        if (core_ok) begin
          if (op == pcrd_pkg::OP_WRITE) begin
            if (is_operand) begin
              dividend_reg[core_id] <= new_dividend;
              divisor_reg[core_id]  <= new_divisor;
              signed_mode[core_id]  <= reg_sel[1];
              dirty_flag[core_id]   <= 1'b1;
            end else if (sel == pcrd_pkg::SEL_QUOTIENT) begin
              quotient_reg[core_id] <= write_data;
              dirty_flag[core_id]   <= 1'b1;
            end else if (sel == pcrd_pkg::SEL_REMAINDER) begin
              remainder_reg[core_id] <= write_data;
              dirty_flag[core_id]    <= 1'b1;
            end
          end else begin
            if (sel == pcrd_pkg::SEL_QUOTIENT) begin
              dirty_flag[core_id] <= 1'b0;
            end
          end
        end
      end
    end
  end

  // a started divide keeps the input side closed until write-back
  `PCRD_ASSERT_NEXT(a_start_busy, div_req.start, state == S_BUSY)
  // the divider only finishes while a divide is outstanding
  `PCRD_ASSERT_SAME(a_done_busy, div_rsp.done, state == S_BUSY)
  // the stored mode of the dividing core matches the divide that was started
  `PCRD_ASSERT_NEXT(a_mode_kept, div_req.start, signed_mode[div_core] == $past(div_req.is_signed))
  // every accepted write returns zero on the next cycle
  `PCRD_ASSERT_NEXT(a_write_zero, accept && (op == pcrd_pkg::OP_WRITE),
                    out_valid && (read_data == '0))
  // a status read of a present core always shows ready
  `PCRD_ASSERT_NEXT(a_status_ready,
                    accept && core_ok && (op == pcrd_pkg::OP_READ) &&
                    (sel == pcrd_pkg::SEL_STATUS),
                    read_data[pcrd_pkg::STAT_READY_BIT])

endmodule

`default_nettype wire

// File: test/per_core_register_divider_tb.sv
// testbench for the per-core register divider: register accesses checked against a predictor
`default_nettype none

module per_core_register_divider_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIRECTED_N     = 26;
  localparam int RANDOM_ITEMS   = 1100;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 40;

  localparam logic [pcrd_pkg::DATA_W-1:0] STATUS_CLEAN =
    pcrd_pkg::DATA_W'(1) << pcrd_pkg::STAT_READY_BIT;
  localparam logic [pcrd_pkg::DATA_W-1:0] STATUS_DIRTY =
    STATUS_CLEAN | (pcrd_pkg::DATA_W'(1) << pcrd_pkg::STAT_DIRTY_BIT);

  logic                          clk;
  logic                          rst        = 1'b1;
  logic                          in_valid   = 1'b0;
  logic                          in_stall;
  logic                          op         = pcrd_pkg::OP_READ;
  logic [pcrd_pkg::CORE_W-1:0]   core_id    = '0;
  logic [2:0]                    reg_sel    = pcrd_pkg::SEL_UDIVIDEND;
  logic [pcrd_pkg::DATA_W-1:0]   write_data = '0;
  logic                          out_valid;
  logic                          out_stall  = 1'b0;
  logic [pcrd_pkg::DATA_W-1:0]   read_data;

  per_core_register_divider dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .core_id    (core_id),
    .reg_sel    (reg_sel),
    .write_data (write_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .read_data  (read_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // per-core copy of the divider registers
  logic [pcrd_pkg::DATA_W-1:0] num_r   [pcrd_pkg::NUM_CORES];
  logic [pcrd_pkg::DATA_W-1:0] den_r   [pcrd_pkg::NUM_CORES];
  logic [pcrd_pkg::DATA_W-1:0] quo_r   [pcrd_pkg::NUM_CORES];
  logic [pcrd_pkg::DATA_W-1:0] rem_r   [pcrd_pkg::NUM_CORES];
  logic                        dirty_r [pcrd_pkg::NUM_CORES];
  logic                        sgn_r   [pcrd_pkg::NUM_CORES];

  logic [pcrd_pkg::DATA_W-1:0] read_data_due [$];
  int unsigned       accepted;
  int unsigned       mismatches;
  int unsigned       send_gap_pct  = 17;
  int unsigned       recv_hold_pct = 49;
  bit                hold_req;

  typedef struct packed {
    logic                        wr;
    logic [pcrd_pkg::CORE_W-1:0] core;
    pcrd_pkg::reg_sel_t          sel;
    logic [pcrd_pkg::DATA_W-1:0] data;
    logic                        typed;
    logic [pcrd_pkg::DATA_W-1:0] want;
  } access_row_t;

  access_row_t directed_rows [DIRECTED_N] = '{
    '{pcrd_pkg::OP_READ,  1'b0, pcrd_pkg::SEL_UDIVIDEND, 32'hFFFF_FFFF, 1'b1, 32'h0},
    '{pcrd_pkg::OP_READ,  1'b1, pcrd_pkg::SEL_STATUS,    32'h0,         1'b1, STATUS_CLEAN},
    '{pcrd_pkg::OP_READ,  1'b0, pcrd_pkg::SEL_QUOTIENT,  32'h0,         1'b1, 32'h0},
    '{pcrd_pkg::OP_WRITE, 1'b0, pcrd_pkg::SEL_SDIVIDEND, 32'h8000_0000, 1'b1, 32'h0},
    '{pcrd_pkg::OP_WRITE, 1'b0, pcrd_pkg::SEL_SDIVISOR,  32'hFFFF_FFFF, 1'b1, 32'h0},
    '{pcrd_pkg::OP_READ,  1'b0, pcrd_pkg::SEL_STATUS,    32'h0,         1'b1, STATUS_DIRTY},
    '{pcrd_pkg::OP_READ,  1'b0, pcrd_pkg::SEL_QUOTIENT,  32'h0,         1'b1, 32'h8000_0000},
    '{pcrd_pkg::OP_READ,  1'b0, pcrd_pkg::SEL_REMAINDER, 32'h0,         1'b1, 32'h0},
    '{pcrd_pkg::OP_READ,  1'b0, pcrd_pkg::SEL_STATUS,    32'h0,         1'b1, STATUS_CLEAN},
    '{pcrd_pkg::OP_WRITE, 1'b0, pcrd_pkg::SEL_UDIVISOR,  32'h0,         1'b1, 32'h0},
    '{pcrd_pkg::OP_READ,  1'b0, pcrd_pkg::SEL_QUOTIENT,  32'h0,         1'b0, 32'h0},
    '{pcrd_pkg::OP_READ,  1'b0, pcrd_pkg::SEL_SDIVISOR,  32'h0,         1'b1, 32'h0},
    '{pcrd_pkg::OP_READ,  1'b0, pcrd_pkg::SEL_SDIVIDEND, 32'h0,         1'b1, 32'h8000_0000},
    '{pcrd_pkg::OP_WRITE, 1'b1, pcrd_pkg::SEL_UDIVIDEND, 32'hFFFF_FFFF, 1'b1, 32'h0},
    '{pcrd_pkg::OP_WRITE, 1'b1, pcrd_pkg::SEL_UDIVISOR,  32'h0000_0001, 1'b1, 32'h0},
    '{pcrd_pkg::OP_READ,  1'b1, pcrd_pkg::SEL_QUOTIENT,  32'h0,         1'b1, 32'hFFFF_FFFF},
    '{pcrd_pkg::OP_READ,  1'b1, pcrd_pkg::SEL_UDIVISOR,  32'h0,         1'b1, 32'h0000_0001},
    '{pcrd_pkg::OP_WRITE, 1'b1, pcrd_pkg::SEL_SDIVIDEND, 32'hFFFF_FFF9, 1'b1, 32'h0},
    '{pcrd_pkg::OP_WRITE, 1'b1, pcrd_pkg::SEL_SDIVISOR,  32'h0000_0002, 1'b1, 32'h0},
    '{pcrd_pkg::OP_READ,  1'b1, pcrd_pkg::SEL_QUOTIENT,  32'h0,         1'b0, 32'h0},
    '{pcrd_pkg::OP_READ,  1'b1, pcrd_pkg::SEL_REMAINDER, 32'h0,         1'b0, 32'h0},
    '{pcrd_pkg::OP_WRITE, 1'b1, pcrd_pkg::SEL_QUOTIENT,  32'h1234_5678, 1'b1, 32'h0},
    '{pcrd_pkg::OP_WRITE, 1'b1, pcrd_pkg::SEL_REMAINDER, 32'hA5A5_A5A5, 1'b1, 32'h0},
    '{pcrd_pkg::OP_WRITE, 1'b1, pcrd_pkg::SEL_STATUS,    32'hFFFF_FFFF, 1'b1, 32'h0},
    '{pcrd_pkg::OP_READ,  1'b1, pcrd_pkg::SEL_STATUS,    32'h0,         1'b1, STATUS_DIRTY},
    '{pcrd_pkg::OP_READ,  1'b1, pcrd_pkg::SEL_UNUSED,    32'h0,         1'b1, 32'h0}
  };

  // applies one register access to the local copy and returns what a read should see
  function automatic logic [pcrd_pkg::DATA_W-1:0] divider_access(input logic wr,
      input logic [pcrd_pkg::CORE_W-1:0] c, input pcrd_pkg::reg_sel_t sel,
      input logic [pcrd_pkg::DATA_W-1:0] data);
    logic [pcrd_pkg::DATA_W-1:0] rd;
    logic [pcrd_pkg::DATA_W-1:0] n, d, an, ad, q, r;
    rd = '0;
    if (int'(c) >= pcrd_pkg::NUM_CORES) return rd;
    if (wr == pcrd_pkg::OP_WRITE) begin
      case (sel)
        pcrd_pkg::SEL_UDIVIDEND, pcrd_pkg::SEL_UDIVISOR,
        pcrd_pkg::SEL_SDIVIDEND, pcrd_pkg::SEL_SDIVISOR: begin
          if (sel == pcrd_pkg::SEL_UDIVISOR || sel == pcrd_pkg::SEL_SDIVISOR) den_r[c] = data;
          else num_r[c] = data;
          dirty_r[c] = 1'b1;
          sgn_r[c]   = (sel == pcrd_pkg::SEL_SDIVIDEND || sel == pcrd_pkg::SEL_SDIVISOR);
          n = num_r[c];
          d = den_r[c];
          // a zero divisor leaves quotient and remainder alone
          if (d != '0) begin
            if (sgn_r[c]) begin
              an = n[pcrd_pkg::DATA_W-1] ? -n : n;
              ad = d[pcrd_pkg::DATA_W-1] ? -d : d;
              q  = an / ad;
              r  = an % ad;
              quo_r[c] = (n[pcrd_pkg::DATA_W-1] ^ d[pcrd_pkg::DATA_W-1]) ? -q : q;
              rem_r[c] = n[pcrd_pkg::DATA_W-1] ? -r : r;
            end else begin
              quo_r[c] = n / d;
              rem_r[c] = n % d;
            end
          end
        end
        pcrd_pkg::SEL_QUOTIENT: begin
          quo_r[c]   = data;
          dirty_r[c] = 1'b1;
        end
        pcrd_pkg::SEL_REMAINDER: begin
          rem_r[c]   = data;
          dirty_r[c] = 1'b1;
        end
        default: ;
      endcase
    end else begin
      case (sel)
        pcrd_pkg::SEL_UDIVIDEND, pcrd_pkg::SEL_SDIVIDEND: rd = num_r[c];
        pcrd_pkg::SEL_UDIVISOR, pcrd_pkg::SEL_SDIVISOR:   rd = den_r[c];
        pcrd_pkg::SEL_QUOTIENT: begin
          rd = quo_r[c];
          dirty_r[c] = 1'b0;
        end
        pcrd_pkg::SEL_REMAINDER: rd = rem_r[c];
        pcrd_pkg::SEL_STATUS:    rd = dirty_r[c] ? STATUS_DIRTY : STATUS_CLEAN;
        default:                 rd = '0;
      endcase
    end
    return rd;
  endfunction

  function automatic logic [pcrd_pkg::DATA_W-1:0] pick_operand(input bit for_divisor);
    logic [pcrd_pkg::DATA_W-1:0] v;
    case ($urandom_range(9))
      0:       v = for_divisor ? '0 : 32'h8000_0000;
      1:       v = 32'hFFFF_FFFF;
      2:       v = 32'h7FFF_FFFF;
      3:       v = 32'h8000_0000;
      4:       v = 32'h0000_0001;
      5, 6:    v = pcrd_pkg::DATA_W'($urandom_range(1, 20));
      default: v = $urandom;
    endcase
    if (for_divisor && $urandom_range(2) == 0) v = pcrd_pkg::DATA_W'($urandom_range(1, 300));
    if ($urandom_range(3) == 0) v = -v;
    return v;
  endfunction

  task automatic put_access(input logic wr, input logic [pcrd_pkg::CORE_W-1:0] c,
                            input pcrd_pkg::reg_sel_t sel,
                            input logic [pcrd_pkg::DATA_W-1:0] data, input logic typed,
                            input logic [pcrd_pkg::DATA_W-1:0] want);
    logic [pcrd_pkg::DATA_W-1:0] predicted;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    op         <= wr;
    core_id    <= c;
    reg_sel    <= sel;
    write_data <= data;
    do @(posedge clk); while (in_stall);
    predicted = divider_access(wr, c, sel, data);
    read_data_due.push_back(typed ? want : predicted);
    accepted++;
  endtask

  // operand pair, then the reads software would do after it
  task automatic run_division(input logic [pcrd_pkg::CORE_W-1:0] c);
    bit sgn, sgn2, swap;
    logic [pcrd_pkg::DATA_W-1:0] num, den;
    sgn  = $urandom_range(1);
    sgn2 = ($urandom_range(7) == 0) ? !sgn : sgn;
    swap = ($urandom_range(4) == 0);
    num  = pick_operand(1'b0);
    den  = pick_operand(1'b1);
    if (swap) begin
      put_access(pcrd_pkg::OP_WRITE, c,
                 sgn ? pcrd_pkg::SEL_SDIVISOR : pcrd_pkg::SEL_UDIVISOR, den, 1'b0, '0);
      put_access(pcrd_pkg::OP_WRITE, c,
                 sgn2 ? pcrd_pkg::SEL_SDIVIDEND : pcrd_pkg::SEL_UDIVIDEND, num, 1'b0, '0);
    end else begin
      put_access(pcrd_pkg::OP_WRITE, c,
                 sgn ? pcrd_pkg::SEL_SDIVIDEND : pcrd_pkg::SEL_UDIVIDEND, num, 1'b0, '0);
      put_access(pcrd_pkg::OP_WRITE, c,
                 sgn2 ? pcrd_pkg::SEL_SDIVISOR : pcrd_pkg::SEL_UDIVISOR, den, 1'b0, '0);
    end
    if ($urandom_range(3) == 0)
      put_access(pcrd_pkg::OP_READ, c, pcrd_pkg::SEL_STATUS, $urandom, 1'b0, '0);
    put_access(pcrd_pkg::OP_READ, c, pcrd_pkg::SEL_QUOTIENT, $urandom, 1'b0, '0);
    put_access(pcrd_pkg::OP_READ, c, pcrd_pkg::SEL_REMAINDER, $urandom, 1'b0, '0);
    if ($urandom_range(1))
      put_access(pcrd_pkg::OP_READ, c, pcrd_pkg::SEL_STATUS, $urandom, 1'b0, '0);
  endtask

  task automatic report_mismatch(input string what, input logic [pcrd_pkg::DATA_W-1:0] want,
                                 input logic [pcrd_pkg::DATA_W-1:0] got);
    mismatches++;
    if (mismatches <= 10) $display("%s: expected %h, got %h", what, want, got);
  endtask

  // receiver side: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      out_stall <= ($urandom_range(99) < recv_hold_pct);
    end
  end

  always @(posedge clk) begin
    logic [pcrd_pkg::DATA_W-1:0] want;
    if (!rst && out_valid && !out_stall) begin
      if (read_data_due.size() == 0) begin
        report_mismatch("read data transfer with nothing pending", '0, read_data);
      end else begin
        want = read_data_due.pop_front();
        if (read_data !== want) report_mismatch("read_data", want, read_data);
      end
    end
  end

  always @(posedge clk) begin
    int unsigned quiet;
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
    else quiet++;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("per_core_register_divider: mismatch");
      $finish;
    end
  end

  initial begin
    int unsigned done_random;
    bit held;
    for (int c = 0; c < pcrd_pkg::NUM_CORES; c++) begin
      num_r[c]   = '0;
      den_r[c]   = '0;
      quo_r[c]   = '0;
      rem_r[c]   = '0;
      dirty_r[c] = 1'b0;
      sgn_r[c]   = 1'b0;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      put_access(directed_rows[i].wr, directed_rows[i].core, directed_rows[i].sel,
                 directed_rows[i].data, directed_rows[i].typed, directed_rows[i].want);

    held = 1'b0;
    while (accepted < DIRECTED_N + RANDOM_ITEMS) begin
      done_random = accepted - DIRECTED_N;
      if (done_random >= 2 * RANDOM_ITEMS / 3) begin
        if (!held) begin
          send_gap_pct  = 0;
          recv_hold_pct = 0;
          hold_req      = 1'b1;
          held          = 1'b1;
        end
      end else if (done_random >= RANDOM_ITEMS / 3) begin
        send_gap_pct  = 49;
        recv_hold_pct = 17;
      end
      if ($urandom_range(9) < 7)
        run_division(pcrd_pkg::CORE_W'($urandom_range(pcrd_pkg::NUM_CORES - 1)));
      else
        put_access(logic'($urandom_range(1)),
                   pcrd_pkg::CORE_W'($urandom_range(pcrd_pkg::NUM_CORES - 1)),
                   pcrd_pkg::reg_sel_t'(3'($urandom_range(7))), $urandom, 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (read_data_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("per_core_register_divider: match");
    else
      $display("per_core_register_divider: mismatch");
    $finish;
  end

endmodule

`default_nettype wire
